@@ src/title_key_normalizer_assert.svh @@
// Assertion macros for the title key normalizer.
`ifndef TITLE_KEY_NORMALIZER_ASSERT_SVH
`define TITLE_KEY_NORMALIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TKN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tkn_pkg.sv @@
`default_nettype none

package tkn_pkg;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CH_OPEN    = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE   = 8'h29;  // ')'
    localparam logic [7:0] CH_DASH    = 8'h2D;  // '-'
    localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
    localparam logic [7:0] CH_COLON   = 8'h3A;  // ':'
    localparam logic [7:0] CH_BANG    = 8'h21;  // '!'
    localparam logic [7:0] CH_SEMI    = 8'h3B;  // ';'
    localparam logic [7:0] CH_QUEST   = 8'h3F;  // '?'
    localparam logic [7:0] CH_LOW_A   = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;  // 'z'
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Register byte address of value_mode
    localparam logic [2:0] ADDR_VALUE_MODE = 3'd0;

    // Result queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        logic [7:0] f;
        f = c | CASE_BIT;
        return (f >= CH_LOW_A) && (f <= CH_LOW_Z);
    endfunction

    function automatic logic is_closer(input logic [7:0] c);
        return (c == CH_CLOSE) || (c == CH_DOT) || (c == CH_COLON) ||
               (c == CH_BANG) || (c == CH_SEMI) || (c == CH_QUEST);
    endfunction

endpackage

`default_nettype wire

@@ src/title_key_normalizer.sv @@
// Title key normalizer: result words are registered in a result queue and driven from its head.
// Throughput: one input word per cycle while the result queue has two free
// slots; output limited to one word per cycle, so items that make two words
// take two output transfers (set by the single output port).
// Reset (synchronous, active low): queue empty, previous byte = space,
// no space pending, value_mode = 0.
`default_nettype none

`include "title_key_normalizer_assert.svh"

module title_key_normalizer
    import tkn_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tlast,   // end_of_string
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tuser,   // [0] out_valid
    output logic             m_axis_tlast,   // out_last
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic             r_value_mode;
    logic [7:0]       r_prev;
    logic             r_pend;
    logic [7:0]       n_prev;
    logic             n_pend;

    t_result          r_q [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;

    t_result          res0;
    t_result          res1;
    logic [1:0]       res_cnt;

    logic             in_acc;
    logic             out_acc;
    logic             cfg_wr;
    logic [7:0]       c;
    logic             ws;
    logic             paren;
    logic             letter;
    logic             extra_sp;
    logic             sp_first;
    logic [7:0]       w;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_VALUE_MODE) ? {31'd0, r_value_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_mode <= 1'b0;
        end else if (cfg_wr && paddr == ADDR_VALUE_MODE) begin
            r_value_mode <= pwdata[0];
        end
    end

    // Handshakes: take a word only when two queue slots are free
    assign s_axis_tready = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    // Classify the incoming byte
    assign c        = s_axis_tdata;
    assign ws       = (c <= SPACE_CHAR);
    assign paren    = (c == CH_OPEN) || (c == CH_DASH);
    assign letter   = is_letter(c);
    assign extra_sp = !r_value_mode && r_prev != SPACE_CHAR &&
                      (paren || (letter && is_closer(r_prev)));
    // a pending space implies the previous byte is a space, so at most one space
    assign sp_first = r_pend || extra_sp;

    // Recase letters in key mode
    always_comb begin
        w = c;
        if (!r_value_mode && letter) begin
            if (is_closer(r_prev) || r_prev == CH_OPEN || r_prev == SPACE_CHAR) begin
                w = c & ~CASE_BIT;
            end else begin
                w = c | CASE_BIT;
            end
        end
    end

    // Build up to two result words and the next state
    always_comb begin
        n_prev  = r_prev;
        n_pend  = r_pend;
        res0    = '{data: 8'd0, valid: 1'b0, last: 1'b0};
        res1    = '{data: 8'd0, valid: 1'b0, last: 1'b0};
        res_cnt = 2'd0;
        if (ws) begin
            if (r_prev != SPACE_CHAR) begin
                n_pend = 1'b1;
                n_prev = SPACE_CHAR;
            end
        end else begin
            n_prev = w;
            n_pend = 1'b0;
            if (sp_first) begin
                res0    = '{data: SPACE_CHAR, valid: 1'b1, last: 1'b0};
                res1    = '{data: w, valid: 1'b1, last: 1'b0};
                res_cnt = 2'd2;
            end else begin
                res0    = '{data: w, valid: 1'b1, last: 1'b0};
                res_cnt = 2'd1;
            end
        end
        // end of string: drop pending space, mark the final word
        if (s_axis_tlast) begin
            n_prev = SPACE_CHAR;
            n_pend = 1'b0;
            if (res_cnt == 2'd0) begin
                res0    = '{data: 8'd0, valid: 1'b0, last: 1'b1};
                res_cnt = 2'd1;
            end else if (res_cnt == 2'd1) begin
                res0.last = 1'b1;
            end else begin
                res1.last = 1'b1;
            end
        end
    end

    // Advance string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= SPACE_CHAR;
            r_pend <= 1'b0;
        end else if (in_acc) begin
            r_prev <= n_prev;
            r_pend <= n_pend;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && res_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (in_acc && res_cnt == 2'd2) begin
            r_q[r_wr_ptr + QAW'(1)] <= res1;
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + QAW'(res_cnt);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + (in_acc ? (QAW+1)'(res_cnt) : '0)
                               - (out_acc ? (QAW+1)'(1) : '0);
        end
    end

    // Drive the output word from the queue head
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_q[r_rd_ptr].data;
    assign m_axis_tuser  = r_q[r_rd_ptr].valid;
    assign m_axis_tlast  = r_q[r_rd_ptr].last;

    `TKN_ASSERT_NOW(a_count_bound, 1'b1, r_count <= (QAW+1)'(QDEPTH),
        "result queue overflow")
    `TKN_ASSERT_NOW(a_pend_space, r_pend, r_prev == SPACE_CHAR,
        "pending space without space as previous byte")
    `TKN_ASSERT_NEXT(a_end_resets, in_acc && s_axis_tlast,
        !r_pend && r_prev == SPACE_CHAR && r_count != '0,
        "string end did not restore state or queue a word")
    `TKN_ASSERT_NOW(a_marker_last, m_axis_tvalid && !m_axis_tuser,
        m_axis_tlast && m_axis_tdata == 8'd0, "end-only marker malformed")

endmodule

`default_nettype wire

@@ verif/title_key_normalizer_tb.sv @@
`timescale 1ns / 1ps

module title_key_normalizer_tb;
    import tkn_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned PHASE_WORDS = 360;
    localparam int unsigned MAX_REPORTS = 10;
    // Byte address with no register behind it
    localparam logic [2:0]  ADDR_UNUSED = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_in_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_byte
    logic        s_axis_tlast = 1'b0;  // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] out_byte
    logic        m_axis_tuser;         // [0] out_valid
    logic        m_axis_tlast;         // out_last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    title_key_normalizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Words waiting to be sent, and normalized words waiting to come out
    t_in_word    char_q[$];
    t_result     norm_expect_q[$];

    // Shadow of the block state
    logic        mode_value = 1'b0;
    logic [7:0]  prev_byte = SPACE_CHAR;
    logic        space_held = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        in_taken = 1'b0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned style = 0;
    int unsigned style_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s expected %0h got %0h", what, exp_v, got_v);
    endtask

    // Work out the normalized words that one input byte produces.
    task automatic normalize_byte(input logic [7:0] ch, input logic eos);
        logic [7:0] prior;
        logic [7:0] folded;
        logic [7:0] main_byte;
        logic       letter;
        logic       closer;
        logic       lead;
        logic       has_main;
        t_result    w;
        prior = prev_byte;
        folded = ch | CASE_BIT;
        letter = (folded >= CH_LOW_A) && (folded <= CH_LOW_Z);
        closer = (prior == CH_CLOSE) || (prior == CH_DOT) || (prior == CH_COLON) ||
                 (prior == CH_BANG) || (prior == CH_SEMI) || (prior == CH_QUEST);
        lead = 1'b0;
        has_main = 1'b0;
        main_byte = '0;
        if (ch <= SPACE_CHAR) begin
            // whitespace only marks a space as pending
            if (prior != SPACE_CHAR) begin
                space_held = 1'b1;
                prev_byte = SPACE_CHAR;
            end
        end else begin
            has_main = 1'b1;
            lead = space_held;
            space_held = 1'b0;
            if (mode_value) begin
                main_byte = ch;
            end else if (ch == CH_OPEN || ch == CH_DASH) begin
                if (prior != SPACE_CHAR)
                    lead = 1'b1;
                main_byte = ch;
            end else if (letter) begin
                if (closer) begin
                    lead = 1'b1;
                    main_byte = ch & ~CASE_BIT;
                end else if (prior == CH_OPEN || prior == SPACE_CHAR) begin
                    main_byte = ch & ~CASE_BIT;
                end else begin
                    main_byte = ch | CASE_BIT;
                end
            end else begin
                main_byte = ch;
            end
            prev_byte = main_byte;
        end
        // a leading space always comes with a main byte, so it is never last
        if (lead) begin
            w.data = SPACE_CHAR;
            w.valid = 1'b1;
            w.last = 1'b0;
            norm_expect_q.insert(norm_expect_q.size(), w);
        end
        if (has_main || eos) begin
            w.data = main_byte;
            w.valid = has_main;
            w.last = eos;
            norm_expect_q.insert(norm_expect_q.size(), w);
        end
        if (eos) begin
            prev_byte = SPACE_CHAR;
            space_held = 1'b0;
        end
    endtask

    // Predict on accepted input, check accepted output, track register writes
    always @(posedge i_clk) begin
        t_result want;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            normalize_byte(s_axis_tdata, s_axis_tlast);
        if (m_axis_tvalid && m_axis_tready) begin
            if (norm_expect_q.size() == 0) begin
                note_mismatch("unexpected output word", '0,
                              {22'd0, m_axis_tuser, m_axis_tlast, m_axis_tdata});
            end else begin
                want = norm_expect_q.pop_front();
                if (m_axis_tdata !== want.data)
                    note_mismatch("out_byte", 32'(want.data), 32'(m_axis_tdata));
                if (m_axis_tuser !== want.valid)
                    note_mismatch("out_valid", 32'(want.valid), 32'(m_axis_tuser));
                if (m_axis_tlast !== want.last)
                    note_mismatch("out_last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
        if (psel && penable && pwrite && pready && paddr == ADDR_VALUE_MODE)
            mode_value <= pwdata[0];
    end

    // Drive input words in bursts with random gaps; hold a word until taken
    always @(negedge i_clk) begin
        t_in_word nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // hold
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (char_q.size() > 0) begin
            nxt = char_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= nxt.ch;
            s_axis_tlast <= nxt.eos;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            end else begin
                burst_left--;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Output ready: one long hold-off on request, otherwise a changing pattern
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD)
                hold_done = 1'b1;
        end else begin
            if (style_left == 0) begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(16, 96);
            end else begin
                style_left--;
            end
            case (style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 4) != 0);
                2: m_axis_tready <= ($urandom_range(0, 4) < 2);
                default: m_axis_tready <= style_left[0];
            endcase
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] ch, input logic eos);
        t_in_word w;
        w.ch = ch;
        w.eos = eos;
        char_q.insert(char_q.size(), w);
    endtask

    task automatic push_text(input string s, input logic eos);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], eos && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                c = CH_LOW_A + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1) != 0)
                    c = c & ~CASE_BIT;
            end
            4: c = ($urandom_range(0, 1) != 0) ? SPACE_CHAR : 8'($urandom_range(1, 32));
            5, 6: begin
                case ($urandom_range(0, 7))
                    0: c = CH_OPEN;
                    1: c = CH_CLOSE;
                    2: c = CH_DASH;
                    3: c = CH_DOT;
                    4: c = CH_COLON;
                    5: c = CH_BANG;
                    6: c = CH_SEMI;
                    default: c = CH_QUEST;
                endcase
            end
            7: c = 8'($urandom_range(128, 255));
            default: c = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    // Queue whole strings until roughly the given number of bytes is waiting
    task automatic add_random_strings(input int unsigned quota);
        int unsigned count;
        int unsigned len;
        count = 0;
        while (count < quota) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            for (int unsigned i = 0; i < len; i++)
                push_byte(pick_char(), i == len - 1);
            count += len;
        end
    endtask

    // Wait until every word went in and every normalized word came out
    task automatic wait_idle();
        while (char_q.size() != 0 || s_axis_tvalid || norm_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write followed by a read back of value_mode
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_VALUE_MODE;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {31'd0, mode_value})
            note_mismatch("value_mode read back", {31'd0, mode_value}, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Key mode: leading whitespace, casing, openers, closers, high byte,
        // trailing space dropped into an end-only marker
        push_byte(8'h01, 1'b0);
        push_text(" aB", 1'b0);
        push_byte(8'h09, 1'b0);
        push_text(" (z)q-", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text(".m@[:k", 1'b0);
        push_byte(SPACE_CHAR, 1'b1);
        push_text("x", 1'b1);
        wait_idle();

        // Switch to value mode in the middle of a string
        push_text("aB", 1'b0);
        wait_idle();
        cfg_write(ADDR_VALUE_MODE, 32'h0000_0001);
        push_text("c (D!e ", 1'b1);
        wait_idle();

        add_random_strings(PHASE_WORDS);
        wait_idle();

        // Back to key mode; a write to the empty address must change nothing
        cfg_write(ADDR_VALUE_MODE, 32'hFFFF_FFFE);
        cfg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        add_random_strings(PHASE_WORDS);
        hold_go = 1'b1;
        wait_idle();

        cfg_write(ADDR_VALUE_MODE, 32'hFFFF_FFFF);
        add_random_strings(PHASE_WORDS);
        wait_idle();

        cfg_write(ADDR_VALUE_MODE, 32'h0000_0000);
        add_random_strings(PHASE_WORDS);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/tkn_pkg.sv
src/title_key_normalizer.sv
verif/title_key_normalizer_tb.sv
